@@ src/scf_pkg.sv @@
// Package with the shared constants, types and helpers of the speculative commit queue bank.
`timescale 1ns / 1ps
package scf_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 64;

    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int RA_W   = $clog2(DEPTH + 1);
    localparam int NSLOT  = NUM_QUEUES * DEPTH;
    localparam int SLOT_W = $clog2(NSLOT);

    localparam int FUNC_W   = 3;
    localparam int QUEUE_W  = 2;
    localparam int DIN_W    = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int DOUT_W   = 64;
    localparam int CFG_W    = 3;
    localparam int FLAG_N   = 6;
    localparam int CMP_W    = (RA_W > COUNT_W) ? RA_W : COUNT_W;

    localparam int S_TDATA_W = ((DIN_W + COUNT_W + 7) / 8) * 8;
    localparam int S_TUSER_W = FUNC_W + QUEUE_W;
    localparam int M_TDATA_W = ((DOUT_W + FLAG_N + 7) / 8) * 8;
    localparam int M_TUSER_W = STATUS_W;
    localparam int S_PAD_W   = S_TDATA_W - (DIN_W + COUNT_W);
    localparam int M_PAD_W   = M_TDATA_W - (DOUT_W + FLAG_N);

    localparam logic [CFG_W-1:0] QUEUES_RESET = CFG_W'(4);

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT      = 3'd0,
        FN_GET      = 3'd1,
        FN_COMMIT   = 3'd2,
        FN_ROLLBACK = 3'd3,
        FN_FINISH   = 3'd4,
        FN_RESET    = 3'd5,
        FN_FLUSH    = 3'd6,
        FN_QUERY    = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 3'd0,
        STS_FULL       = 3'd1,
        STS_EMPTY      = 3'd2,
        STS_BAD_QUEUE  = 3'd3,
        STS_FLUSH_BUSY = 3'd4,
        STS_CLAMPED    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic exec;
        logic commit;
        logic done;
    } seq_ctl_t;

    typedef struct packed {
        logic start;
        logic commit_go;
        logic commit_last;
        logic out_free;
    } seq_stat_t;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                    input logic [IDX_W-1:0] idx);
        return SLOT_W'(q) * SLOT_W'(DEPTH) + SLOT_W'(idx);
    endfunction

endpackage

@@ src/scf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module scf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/scf_seq.sv @@
// Sequencer that steps one item through execute, commit sweep and result hand-off.
`timescale 1ns / 1ps
module scf_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scf_pkg::seq_stat_t   stat,
    output scf_pkg::seq_ctl_t    ctl
);

    import scf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ctl.in_ready = 1'b1;
                if (stat.start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = stat.commit_go ? ST_COMMIT : ST_DONE;
            end
            ST_COMMIT: begin
                ctl.commit = 1'b1;
                if (stat.commit_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    ctl.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/speculative_commit_fifo.sv @@
// Top level of the speculative commit queue bank: queue state, slot memory and result register.
//
// A bank of ring queues with a valid bit per slot, a write pointer, a committed
// read pointer and a speculative read pointer. Each item on the s_ channel is one
// operation (put, get, commit, rollback, finish, reset or flush request, query)
// on one queue; each item yields exactly one result item on the m_ channel.
// The queue count register is written through cfg_we and cfg_wdata while idle;
// the user must keep to this, as the block itself does not enforce it. An item
// is taken in the cycle s_tready is high, then executed in the execute state,
// and its result is loaded into the result register in the done state, which
// also raises m_tvalid. A commit frees its slots one per cycle through the
// shared pointer stepper in the commit state, before its done state. One item
// is in flight at a time; no new item is taken until the last result is handed off.
// The result register lets the next item be accepted while a result waits;
// while the receiver stalls, a finished result waits in the done state and
// no further item is taken. Reset clears all valid bits, pointers and flags at
// once, sets every drained flag and restores the queue count to four.
`timescale 1ns / 1ps
module speculative_commit_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [scf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [scf_pkg::S_TDATA_W-1:0] s_tdata,  // data_in, count, zero fill
    input  logic [scf_pkg::S_TUSER_W-1:0] s_tuser,  // func, queue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_out, is_full, is_empty, finished, reset_pending, flush_pending,
    // process_done, zero fill
    output logic [scf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [scf_pkg::M_TUSER_W-1:0] m_tuser   // status
);

    import scf_pkg::*;

    seq_ctl_t  ctl;
    seq_stat_t stat;

    logic [CFG_W-1:0]      qiu_reg;
    func_t                 func_reg;
    logic [QUEUE_W-1:0]    q_reg;
    logic [DIN_W-1:0]      din_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [RA_W-1:0]       cnt_left_reg;
    status_t               status_reg;
    logic [DATA_WIDTH-1:0] dout_reg;

    logic [NSLOT-1:0]      valid_reg;
    logic [IDX_W-1:0]      wi_reg   [NUM_QUEUES];
    logic [IDX_W-1:0]      ci_reg   [NUM_QUEUES];
    logic [IDX_W-1:0]      ri_reg   [NUM_QUEUES];
    logic [RA_W-1:0]       rah_reg  [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] rst_flag_reg;
    logic [NUM_QUEUES-1:0] fl_flag_reg;
    logic [NUM_QUEUES-1:0] fin_flag_reg;
    logic [NUM_QUEUES-1:0] drn_flag_reg;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    logic                  accept;
    logic [QIDX_W-1:0]     s_qi;
    logic [QIDX_W-1:0]     qi;
    logic                  bad;
    logic [SLOT_W-1:0]     w_addr;
    logic [SLOT_W-1:0]     r_addr;
    logic [SLOT_W-1:0]     c_addr;
    logic [SLOT_W-1:0]     ram_raddr;
    logic                  empty;
    logic                  put_ok;
    logic                  over;
    logic [RA_W-1:0]       eff;
    logic                  ram_we;
    logic [DATA_WIDTH-1:0] ram_rdata;
    status_t               status_next;

    assign accept = s_tvalid && ctl.in_ready;
    assign s_qi   = QIDX_W'(s_tuser[FUNC_W +: QUEUE_W]);
    assign qi     = QIDX_W'(q_reg);

    assign bad    = (CFG_W'(q_reg) >= qiu_reg) || (int'(q_reg) >= NUM_QUEUES);
    assign w_addr = slot_addr(qi, wi_reg[qi]);
    assign r_addr = slot_addr(qi, ri_reg[qi]);
    assign c_addr = slot_addr(qi, ci_reg[qi]);
    assign empty  = !valid_reg[r_addr] || (rah_reg[qi] >= RA_W'(DEPTH));
    assign put_ok = !valid_reg[w_addr];
    assign over   = CMP_W'(cnt_reg) > CMP_W'(rah_reg[qi]);
    assign eff    = over ? rah_reg[qi] : RA_W'(cnt_reg);
    assign ram_we = ctl.exec && !bad && (func_reg == FN_PUT) && put_ok;

    assign ram_raddr = slot_addr(s_qi, ri_reg[s_qi]);

    assign stat.start       = accept;
    assign stat.commit_go   = !bad && (func_reg == FN_COMMIT) && (eff != '0);
    assign stat.commit_last = (cnt_left_reg == RA_W'(1));
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    scf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    scf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NSLOT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (w_addr),
        .wdata (din_reg[DATA_WIDTH-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        status_next = STS_OK;
        if (bad) begin
            status_next = STS_BAD_QUEUE;
        end else begin
            unique case (func_reg)
                FN_PUT:    status_next = put_ok ? STS_OK : STS_FULL;
                FN_GET:    status_next = empty ? STS_EMPTY : STS_OK;
                FN_COMMIT: status_next = over ? STS_CLAMPED : STS_OK;
                FN_FLUSH:  status_next = drn_flag_reg[qi] ? STS_OK : STS_FLUSH_BUSY;
                default:   status_next = STS_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= func_t'(s_tuser[FUNC_W-1:0]);
            q_reg    <= s_tuser[FUNC_W +: QUEUE_W];
            din_reg  <= s_tdata[DIN_W-1:0];
            cnt_reg  <= s_tdata[DIN_W +: COUNT_W];
        end
        if (ctl.exec) begin
            status_reg <= status_next;
            dout_reg   <= (!bad && func_reg == FN_GET && !empty) ? ram_rdata : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qiu_reg      <= QUEUES_RESET;
            valid_reg    <= '0;
            rst_flag_reg <= '0;
            fl_flag_reg  <= '0;
            fin_flag_reg <= '0;
            drn_flag_reg <= '1;
            cnt_left_reg <= '0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                wi_reg[q]  <= '0;
                ci_reg[q]  <= '0;
                ri_reg[q]  <= '0;
                rah_reg[q] <= '0;
            end
        end else begin
            if (cfg_we) begin
                qiu_reg <= cfg_wdata;
            end
            if (ctl.exec && !bad) begin
                unique case (func_reg)
                    FN_PUT: begin
                        if (put_ok) begin
                            valid_reg[w_addr] <= 1'b1;
                            drn_flag_reg[qi]  <= 1'b0;
                            wi_reg[qi]        <= next_slot(wi_reg[qi]);
                        end
                    end
                    FN_GET: begin
                        if (empty) begin
                            rst_flag_reg[qi] <= 1'b0;
                            fl_flag_reg[qi]  <= 1'b0;
                            drn_flag_reg[qi] <= 1'b1;
                        end else begin
                            ri_reg[qi]  <= next_slot(ri_reg[qi]);
                            rah_reg[qi] <= rah_reg[qi] + 1'b1;
                        end
                    end
                    FN_COMMIT: begin
                        rah_reg[qi]  <= rah_reg[qi] - eff;
                        cnt_left_reg <= eff;
                    end
                    FN_ROLLBACK: begin
                        ri_reg[qi]  <= ci_reg[qi];
                        rah_reg[qi] <= '0;
                    end
                    FN_FINISH: begin
                        fin_flag_reg[qi] <= 1'b1;
                    end
                    FN_RESET: begin
                        rst_flag_reg[qi] <= 1'b1;
                    end
                    FN_FLUSH: begin
                        if (drn_flag_reg[qi]) begin
                            fl_flag_reg[qi] <= 1'b1;
                        end
                    end
                    FN_QUERY: begin
                        if (fin_flag_reg[qi]) begin
                            drn_flag_reg[qi] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (ctl.commit) begin
                valid_reg[c_addr] <= 1'b0;
                ci_reg[qi]        <= next_slot(ci_reg[qi]);
                cnt_left_reg      <= cnt_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.done) begin
            m_tuser_reg <= status_reg;
            if (bad) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {{M_PAD_W{1'b0}},
                                drn_flag_reg[qi],
                                fl_flag_reg[qi],
                                rst_flag_reg[qi],
                                fin_flag_reg[qi],
                                empty,
                                valid_reg[w_addr],
                                DOUT_W'(dout_reg)};
            end
        end
    end

    assign s_tready = ctl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again while an item is in flight");

    a_commit_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit |-> (!s_tready && cnt_left_reg != '0))
        else $error("commit sweep running without a pending count");

    a_bad_queue_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STS_BAD_QUEUE) |-> (m_tdata == '0))
        else $error("bad queue result carries nonzero fields");

    a_read_ahead_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.exec |-> (rah_reg[qi] <= RA_W'(DEPTH)))
        else $error("read-ahead count beyond queue depth");

endmodule
